@@ rtl/mmad_pkg.sv @@
// Shared types and constants for the memory map address decoder.
// Holds item structs, descriptor layout and status codes; no dependencies.
`default_nettype none

package mmad_pkg;

    // Table geometry
    localparam int MAX_DESCRIPTORS = 16;
    localparam int IDX_W = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
    localparam int CNT_W = $clog2(MAX_DESCRIPTORS + 1);
    localparam int SLOT_W = 4;
    localparam int CFG_W = 5;

    // Item operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_MAP  = 2'd1,
        STATUS_NO_DESC = 2'd2,
        STATUS_NO_DATA = 2'd3
    } status_t;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] entry_slot;
        logic [31:0]       load_start;
        logic [31:0]       load_length;
        logic [31:0]       load_select;
        logic [31:0]       load_disconnect;
        logic              load_has_data;
        logic [31:0]       lookup_address;
        logic [31:0]       request_size;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] hit_slot;
        logic [31:0]       byte_offset;
        logic [31:0]       send_size;
    } out_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] select;
        logic [31:0] disconnect;
        logic        has_data;
    } desc_t;

endpackage

`default_nettype wire

@@ rtl/mmad_desc_ram.sv @@
// Descriptor table: one write port, one registered read port.
// Depends on mmad_pkg for the descriptor layout and table depth.
`default_nettype none

module mmad_desc_ram
    import mmad_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire desc_t            wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output desc_t                 rd_data
);

    desc_t mem [MAX_DESCRIPTORS];
    desc_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/mmad_squeeze.sv @@
// Iterative bit compaction: removes one disconnect-mask bit per cycle.
// Depends on mmad_pkg only through the common import convention.
`default_nettype none

module mmad_squeeze
    import mmad_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] value,
    input  wire logic [31:0] gap,
    output logic             done,
    output logic [31:0]      result
);

    logic [31:0] val_reg;
    logic [31:0] val_next;
    logic [31:0] mask_reg;
    logic [31:0] mask_next;
    logic        run_reg;
    logic [31:0] below;

    // One step: drop the bit under the lowest set gap bit, close the hole
    always_comb
    begin
        below     = (mask_reg - 32'd1) & ~mask_reg;
        val_next  = (val_reg & below) | ((val_reg >> 1) & ~below);
        mask_next = (mask_reg & (mask_reg - 32'd1)) >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            mask_reg <= '0;
            val_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            mask_reg <= gap;
            val_reg  <= value;
        end
        else if (run_reg && (mask_reg != 32'd0))
        begin
            mask_reg <= mask_next;
            val_reg  <= val_next;
        end
        else if (run_reg)
        begin
            run_reg <= 1'b0;
        end
    end

    assign done   = run_reg && (mask_reg == 32'd0);
    assign result = val_reg;

endmodule

`default_nettype wire

@@ rtl/memory_map_address_decoder.sv @@
// Top level of the memory map address decoder: sequencer, table and compaction unit.
// Depends on mmad_pkg, mmad_desc_ram and mmad_squeeze.
`default_nettype none

// A load item writes one descriptor and goes to S_RESULT, which posts its answer once
// the response register is free. A lookup item walks the first descriptor_count entries
// through one registered table read port: a range entry (select mask zero) is decided
// in S_EVAL, a masked entry whose select bits agree runs through the shared compaction
// unit in S_SQZ, other entries miss in S_EVAL; a hit passes S_HIT, and S_SIZE when the
// send size is formed, then S_RESULT posts the answer. req_ready is high only while no
// item is in work; a finished answer waits in the response register while the next item
// is taken. The user writes descriptor_count through cfg_wr_en/cfg_wr_data only while
// idle, not enforced by the block; values above the table depth act as the full table.

module memory_map_address_decoder
    import mmad_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire in_t              req_item,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output out_t                  rsp_item,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SQZ,
        S_HIT,
        S_SIZE,
        S_RESULT
    } state_t;

    state_t            state_reg;
    logic [CFG_W-1:0]  count_cfg_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_clamped;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_plus;
    logic [31:0]       addr_reg;
    logic [31:0]       size_reg;
    logic [31:0]       off_reg;
    logic [31:0]       left_reg;
    out_t              res_reg;
    out_t              rsp_item_reg;
    logic              rsp_valid_reg;

    logic              accept;
    logic              wr_en;
    desc_t             wr_desc;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    desc_t             rd_desc;

    logic [32:0]       diff_wide;
    logic              range_hit;
    logic              sel_ok;
    logic              entry_hit;
    logic              entry_miss;
    logic [31:0]       hit_off;
    logic              more_entries;
    logic              sqz_start;
    logic              sqz_done;
    logic [31:0]       sqz_result;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // Clamp the configured count to the table depth
    assign count_clamped = (32'(count_cfg_reg) > MAX_DESCRIPTORS)
                           ? CNT_W'(MAX_DESCRIPTORS) : CNT_W'(count_cfg_reg);

    // Hold the descriptor count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            count_cfg_reg <= cfg_wr_data;
        end
    end

    // Table write from a load item
    assign wr_en = accept && (req_item.op == OP_LOAD)
                   && (32'(req_item.entry_slot) < MAX_DESCRIPTORS);
    always_comb
    begin
        wr_desc.start      = req_item.load_start;
        wr_desc.length     = req_item.load_length;
        wr_desc.select     = req_item.load_select;
        wr_desc.disconnect = req_item.load_disconnect;
        wr_desc.has_data   = req_item.load_has_data;
    end

    // Decode the entry that was just read
    always_comb
    begin
        diff_wide    = {1'b0, addr_reg} - {1'b0, rd_desc.start};
        range_hit    = !diff_wide[32] && (diff_wide[31:0] < rd_desc.length);
        sel_ok       = ((rd_desc.start ^ addr_reg) & rd_desc.select) == 32'd0;
        idx_plus     = CNT_W'(idx_reg) + CNT_W'(1);
        more_entries = idx_plus < count_reg;
        entry_hit    = 1'b0;
        entry_miss   = 1'b0;
        sqz_start    = 1'b0;
        hit_off      = diff_wide[31:0];
        unique case (state_reg)
            S_EVAL:
            begin
                if (rd_desc.select == 32'd0)
                begin
                    entry_hit  = range_hit;
                    entry_miss = !range_hit;
                end
                else if (sel_ok)
                begin
                    sqz_start = 1'b1;
                end
                else
                begin
                    entry_miss = 1'b1;
                end
            end
            S_SQZ:
            begin
                hit_off = sqz_result;
                if (sqz_done)
                begin
                    entry_hit  = sqz_result < rd_desc.length;
                    entry_miss = !(sqz_result < rd_desc.length);
                end
            end
            default:
            begin
                entry_hit = 1'b0;
            end
        endcase
    end

    // Issue table reads: first entry on a lookup, next entry on a miss
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (accept && (req_item.op == OP_LOOKUP))
        begin
            rd_en = 1'b1;
        end
        else if (entry_miss && more_entries)
        begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(idx_plus);
        end
    end

    mmad_desc_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(req_item.entry_slot)),
        .wr_data (wr_desc),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_desc)
    );

    mmad_squeeze u_squeeze (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sqz_start),
        .value  (diff_wide[31:0]),
        .gap    (rd_desc.disconnect),
        .done   (sqz_done),
        .result (sqz_result)
    );

    // Sequencer and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_item_reg  <= '0;
            res_reg       <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            size_reg      <= '0;
            off_reg       <= '0;
            left_reg      <= '0;
        end
        else
        begin
            // Drop a taken response unless a new one is posted in its place
            if (rsp_valid_reg && rsp_ready && (state_reg != S_RESULT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        addr_reg  <= req_item.lookup_address;
                        size_reg  <= req_item.request_size;
                        count_reg <= count_clamped;
                        idx_reg   <= '0;
                        if (req_item.op == OP_LOAD)
                        begin
                            res_reg   <= '{status: STATUS_OK, hit_slot: '0,
                                           byte_offset: '0, send_size: '0};
                            state_reg <= S_RESULT;
                        end
                        else if (count_clamped == '0)
                        begin
                            res_reg   <= '{status: STATUS_NO_MAP, hit_slot: '0,
                                           byte_offset: '0, send_size: '0};
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_EVAL, S_SQZ:
                begin
                    if (entry_hit)
                    begin
                        off_reg   <= hit_off;
                        state_reg <= S_HIT;
                    end
                    else if (entry_miss)
                    begin
                        if (more_entries)
                        begin
                            idx_reg   <= IDX_W'(idx_plus);
                            state_reg <= S_EVAL;
                        end
                        else
                        begin
                            res_reg   <= '{status: STATUS_NO_DESC, hit_slot: '0,
                                           byte_offset: '0, send_size: '0};
                            state_reg <= S_RESULT;
                        end
                    end
                    else if (sqz_start)
                    begin
                        state_reg <= S_SQZ;
                    end
                end
                S_HIT:
                begin
                    res_reg.hit_slot    <= SLOT_W'(idx_reg);
                    res_reg.byte_offset <= off_reg;
                    res_reg.send_size   <= '0;
                    if (!rd_desc.has_data)
                    begin
                        res_reg.status <= STATUS_NO_DATA;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        res_reg.status <= STATUS_OK;
                        left_reg       <= rd_desc.length - off_reg;
                        state_reg      <= S_SIZE;
                    end
                end
                S_SIZE:
                begin
                    res_reg.send_size <= (left_reg < size_reg) ? left_reg : size_reg;
                    state_reg         <= S_RESULT;
                end
                S_RESULT:
                begin
                    // Post the item once the response register is free
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_item_reg  <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/mmad_checker.sv @@
// Port-level checks for the memory map address decoder, bound to the top level.
// Depends on mmad_pkg and on the port list of memory_map_address_decoder.
`default_nettype none

module mmad_checker
    import mmad_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire out_t             rsp_item
);

    // A stalled response item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("response item changed while stalled");

    // One item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in work");

    // Only an ok answer carries a send size
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.status != STATUS_OK) |-> rsp_item.send_size == 32'd0)
        else $error("send size on a failed lookup");

    // Miss and empty-map answers carry no slot or offset
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.status == STATUS_NO_MAP || rsp_item.status == STATUS_NO_DESC)
        |-> rsp_item.hit_slot == '0 && rsp_item.byte_offset == 32'd0)
        else $error("slot or offset on a miss");

    // No response during reset
    assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid in reset");

endmodule

bind memory_map_address_decoder mmad_checker u_mmad_checker (.*);

`default_nettype wire
